// ----- rtl/core/deq_pkg.sv -----
// shared types and operation codes for the double-ended queue
`default_nettype none

package deq_pkg;

   // operation codes carried in the request tuser
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_SIZE       = 3'd4;
   localparam logic [2:0] OP_EMPTY      = 3'd5;
   localparam logic [2:0] OP_PEEK_FRONT = 3'd6;
   localparam logic [2:0] OP_PEEK_BACK  = 3'd7;

   // per-cycle control broadcast along one chain of cells
   typedef struct packed {
      logic shift_in;    // whole chain moves away from cell 0, new word enters cell 0
      logic shift_out;   // whole chain moves toward cell 0, cell 0 word leaves
      logic tail_write;  // the cell just past the last occupied one takes the new word
   } chain_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/core/deq_cell.sv -----
// one storage cell of a deque chain, exchanging its word with its neighbors
`default_nettype none

module deq_cell
   import deq_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  wire                        clock,
   input  chain_ctrl_type             ctrl,
   input  wire                        tail_sel,   // this cell sits at the current count
   input  wire  [DATA_WIDTH-1:0]      from_prev,  // neighbor nearer cell 0
   input  wire  [DATA_WIDTH-1:0]      from_next,  // neighbor farther from cell 0
   input  wire  [DATA_WIDTH-1:0]      push_word,
   output logic [DATA_WIDTH-1:0]      word_out
);

   logic [DATA_WIDTH-1:0] word_ff;
   logic [DATA_WIDTH-1:0] word_in;

   // pick the word this cell holds next cycle
   always_comb begin
      word_in = word_ff;
      if (ctrl.shift_in) begin
         word_in = from_prev;
      end else if (ctrl.shift_out) begin
         word_in = from_next;
      end else if (ctrl.tail_write && tail_sel) begin
         word_in = push_word;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

`default_nettype wire

// ----- rtl/core/deq_chain.sv -----
// row of deque cells with the fixed end at cell 0 and the moving end at the count
`default_nettype none

module deq_chain
   import deq_pkg::*;
#(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32,
   parameter int CNT_W      = $clog2(DEPTH + 1)
) (
   input  wire                        clock,
   input  chain_ctrl_type             ctrl,
   input  wire  [CNT_W-1:0]           count,
   input  wire  [DATA_WIDTH-1:0]      push_word,
   output logic [DATA_WIDTH-1:0]      head_word
);

   logic [DATA_WIDTH-1:0] cell_word [DEPTH];

   // each cell, its neighbor wiring and its tail decode
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_word;
      logic [DATA_WIDTH-1:0] next_word;
      logic                  tail_sel;

      if (i == 0) begin : g_first
         assign prev_word = push_word;
      end else begin : g_mid_prev
         assign prev_word = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_word = cell_word[i];
      end else begin : g_mid_next
         assign next_word = cell_word[i+1];
      end

      assign tail_sel = (count == CNT_W'(i));

      deq_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .tail_sel  (tail_sel),
         .from_prev (prev_word),
         .from_next (next_word),
         .push_word (push_word),
         .word_out  (cell_word[i])
      );
   end

   assign head_word = cell_word[0];

endmodule

`default_nettype wire

// ----- rtl/core/double_ended_queue.sv -----
// top level of the double-ended queue built from two mirrored chains of cells
// responses are registered: a result appears on the rsp side in the cycle after its request transaction
// throughput: one transaction per cycle while the rsp side is not stalled; every operation is a single cell update step
// the front chain keeps the front word in cell 0, the back chain keeps the back word in cell 0
// reset clears the entry count and the response valid; cell contents are not cleared
`default_nettype none

module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] data_value
   input  wire  [2:0]  req_tuser,   // [2:0] op
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_value
   output logic        rsp_tuser    // [0] was_empty
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [31:0]            rsp_data_ff;
   logic                   rsp_user_ff;

   logic                   req_accept;
   logic [2:0]             req_op;
   logic signed [31:0]     req_value;
   logic [DATA_WIDTH-1:0]  push_word;
   logic                   is_empty;
   logic                   is_full;
   chain_ctrl_type         front_ctrl;
   chain_ctrl_type         back_ctrl;
   logic [DATA_WIDTH-1:0]  front_word;
   logic [DATA_WIDTH-1:0]  back_word;
   logic signed [31:0]     front_value;
   logic signed [31:0]     back_value;
   logic                   rsp_load;
   logic [31:0]            result_value;
   logic                   result_empty;

   // request transaction and field extraction
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;
   assign req_op     = req_tuser;
   assign req_value  = signed'(req_tdata);
   assign push_word  = DATA_WIDTH'(req_value);

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(DEPTH));

   // stored words sign extended to the result width
   assign front_value = 32'(signed'(front_word));
   assign back_value  = 32'(signed'(back_word));

   // operation decode
   always_comb begin
      front_ctrl   = '0;
      back_ctrl    = '0;
      count_in     = count_ff;
      rsp_load     = 1'b0;
      result_value = '0;
      result_empty = 1'b0;
      if (req_accept) begin
         unique case (req_op)
            OP_PUSH_FRONT: begin
               if (!is_full) begin
                  front_ctrl.shift_in = 1'b1;
                  back_ctrl.tail_write = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_PUSH_BACK: begin
               if (!is_full) begin
                  back_ctrl.shift_in = 1'b1;
                  front_ctrl.tail_write = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
               rsp_load = 1'b1;
               if (is_empty) begin
                  result_value = '1;
                  result_empty = 1'b1;
               end else begin
                  result_value = front_value;
                  if (req_op == OP_POP_FRONT) begin
                     front_ctrl.shift_out = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
               rsp_load = 1'b1;
               if (is_empty) begin
                  result_value = '1;
                  result_empty = 1'b1;
               end else begin
                  result_value = back_value;
                  if (req_op == OP_POP_BACK) begin
                     back_ctrl.shift_out = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
            end
            OP_SIZE: begin
               rsp_load = 1'b1;
               result_value = 32'(count_ff);
            end
            OP_EMPTY: begin
               rsp_load = 1'b1;
               result_value = 32'(is_empty);
            end
            default: begin
               rsp_load = 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_tready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result_value;
         rsp_user_ff <= result_empty;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // front-ordered chain
   deq_chain #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
   ) u_front_chain (
      .clock     (clock),
      .ctrl      (front_ctrl),
      .count     (count_ff),
      .push_word (push_word),
      .head_word (front_word)
   );

   // back-ordered chain
   deq_chain #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W)
   ) u_back_chain (
      .clock     (clock),
      .ctrl      (back_ctrl),
      .count     (count_ff),
      .push_word (push_word),
      .head_word (back_word)
   );

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// self-checking testbench for the double-ended queue with a predictor and random stimulus
`timescale 1ns / 100ps

module testbench;
   import deq_pkg::*;

   localparam int DEPTH       = 1024;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 40;

   // one request transaction as queued for the driver
   typedef struct {
      logic [2:0]  op;
      logic [31:0] data;
      bit          calm;
   } deq_request_type;

   // one expected response transaction
   typedef struct {
      logic [31:0] value;
      logic        was_empty;
   } deq_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] data_value
   logic [2:0]  req_tuser = '0;   // [2:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] result_value
   logic        rsp_tuser;        // [0] was_empty

   deq_request_type pending_requests[$];
   deq_result_type  expected_results[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              gap_left = 0;
   int              stall_left = 0;
   bit              calm_mode = 1'b0;
   int              planned_count = 0;

   // predicted deque contents
   logic [31:0] entry_mem [0:DEPTH-1];
   logic [9:0]  front_slot = '0;
   logic [10:0] held_count = '0;

   double_ended_queue #(.DEPTH(DEPTH), .DATA_WIDTH(32)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // apply one operation to the predicted deque and work out its response
   task automatic predict_deque(input logic [2:0] op, input logic [31:0] data,
                                output bit produces, output deq_result_type res);
      res.value = '0;
      res.was_empty = 1'b0;
      produces = 1'b1;
      case (op)
         OP_PUSH_FRONT: begin
            produces = 1'b0;
            if (held_count < DEPTH) begin
               front_slot = front_slot - 10'd1;
               entry_mem[front_slot] = data;
               held_count = held_count + 11'd1;
            end
         end
         OP_PUSH_BACK: begin
            produces = 1'b0;
            if (held_count < DEPTH) begin
               entry_mem[10'(front_slot + held_count[9:0])] = data;
               held_count = held_count + 11'd1;
            end
         end
         OP_SIZE: res.value = 32'(held_count);
         OP_EMPTY: res.value = (held_count == 0) ? 32'd1 : 32'd0;
         default: begin
            if (held_count == 0) begin
               res.value = '1;
               res.was_empty = 1'b1;
            end else if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) begin
               res.value = entry_mem[front_slot];
               if (op == OP_POP_FRONT) begin
                  front_slot = front_slot + 10'd1;
                  held_count = held_count - 11'd1;
               end
            end else begin
               res.value = entry_mem[10'(front_slot + held_count[9:0] - 10'd1)];
               if (op == OP_POP_BACK) held_count = held_count - 11'd1;
            end
         end
      endcase
   endtask

   // queue one request and track the fill level that stimulus planning needs
   task automatic add_request(input logic [2:0] op, input logic [31:0] data, input bit calm);
      deq_request_type item;
      item.op = op;
      item.data = data;
      item.calm = calm;
      pending_requests = {pending_requests, item};
      if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && planned_count < DEPTH) planned_count++;
      else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && planned_count > 0) planned_count--;
   endtask

   // random word, with the extremes mixed in
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // random operation with a given share of pushes
   function automatic logic [2:0] pick_op(input int push_pct);
      if ($urandom_range(1, 100) <= push_pct)
         return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      return 3'($urandom_range(OP_POP_FRONT, OP_PEEK_BACK));
   endfunction

   task automatic add_random(input int n, input int push_pct, input bit calm);
      for (int i = 0; i < n; i++) add_request(pick_op(push_pct), pick_word(), calm);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   // driver: presents queued requests, with random idle bursts between them
   always @(posedge clock) begin
      deq_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            item = pending_requests[0];
            pending_requests.delete(0);
            calm_mode = item.calm;
            req_tvalid <= 1'b1;
            req_tdata <= item.data;
            req_tuser <= item.op;
            if (!item.calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 5);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: checks response transactions, predicts accepted requests, stalls at random
   always @(posedge clock) begin
      deq_result_type oldest;
      deq_result_type fresh;
      bit             produces;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("response %h/%b with none expected", rsp_tdata,
                                         rsp_tuser));
            end else begin
               oldest = expected_results[0];
               expected_results.delete(0);
               if (rsp_tdata !== oldest.value)
                  report_mismatch($sformatf("result_value %h, predicted %h", rsp_tdata,
                                            oldest.value));
               if (rsp_tuser !== oldest.was_empty)
                  report_mismatch($sformatf("was_empty %b, predicted %b", rsp_tuser,
                                            oldest.was_empty));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_deque(req_tuser, req_tdata, produces, fresh);
            if (produces) expected_results = {expected_results, fresh};
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm_mode && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: queries and pops on an empty deque
      add_request(OP_SIZE, 32'h0, 1'b0);
      add_request(OP_EMPTY, 32'h0, 1'b0);
      add_request(OP_POP_FRONT, 32'hffff_ffff, 1'b0);
      add_request(OP_POP_BACK, 32'h0, 1'b0);
      add_request(OP_PEEK_FRONT, 32'h0, 1'b0);
      add_request(OP_PEEK_BACK, 32'hffff_ffff, 1'b0);
      // extremes at both ends, head wraps below zero
      add_request(OP_PUSH_FRONT, 32'h8000_0000, 1'b0);
      add_request(OP_PUSH_BACK, 32'h7fff_ffff, 1'b0);
      add_request(OP_PUSH_FRONT, 32'hffff_ffff, 1'b0);
      add_request(OP_PUSH_BACK, 32'h0000_0000, 1'b0);
      add_request(OP_PEEK_FRONT, 32'h0, 1'b0);
      add_request(OP_PEEK_BACK, 32'h0, 1'b0);
      add_request(OP_SIZE, 32'h0, 1'b0);
      add_request(OP_EMPTY, 32'h0, 1'b0);
      add_request(OP_POP_FRONT, 32'h0, 1'b0);
      add_request(OP_POP_BACK, 32'h0, 1'b0);
      add_request(OP_POP_BACK, 32'h0, 1'b0);
      add_request(OP_POP_FRONT, 32'h0, 1'b0);
      // removing the only element from the back, then from the end opposite the push
      add_request(OP_PUSH_BACK, 32'h1234_5678, 1'b0);
      add_request(OP_POP_BACK, 32'h0, 1'b0);
      add_request(OP_EMPTY, 32'h0, 1'b0);
      add_request(OP_PUSH_FRONT, 32'h5a5a_5a5a, 1'b0);
      add_request(OP_POP_BACK, 32'h0, 1'b0);
      add_request(OP_PUSH_BACK, 32'ha5a5_a5a5, 1'b0);
      add_request(OP_POP_FRONT, 32'h0, 1'b0);
      add_request(OP_SIZE, 32'h0, 1'b0);

      // shallow random mix, empty cases frequent
      add_random(120, 50, 1'b0);

      // sender holds off until every response is back
      wait_drained();

      // fill to full with queries along the way, then pushes that get dropped
      while (planned_count < DEPTH) add_request(pick_op(95), pick_word(), 1'b0);
      add_random(12, 70, 1'b0);
      add_request(OP_SIZE, 32'h0, 1'b0);
      // churn near full
      add_random(60, 50, 1'b0);
      // last stretch without idling on either side
      add_random(60, 40, 1'b1);

      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
